/* rtl/asrs_pkg.sv */
// ---------------------------------------------------------------------------
// asrs_pkg - shared types and constants of the ADC serial read sequencer
// Command codes, queue entry layout, result layout and sequencer states.
// ---------------------------------------------------------------------------
package asrs_pkg;

  // Converter geometry
  localparam int CHANNELS   = 8;
  localparam int CH_W       = 3;
  localparam int DATA_BITS  = 12;
  localparam int CMD_BITS   = 5;
  localparam int SPARE_BITS = 2;
  localparam int BIT_CNT_W  = 4;

  // Front-to-back queue
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;

  // Classified item kinds
  typedef enum logic [1:0] {
    K_PLAIN = 2'd0,
    K_READ  = 2'd1,
    K_SCAN  = 2'd2,
    K_BAD   = 2'd3
  } kind_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMD   = 5'b00010,
    ST_SPARE = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_GAP   = 5'b10000
  } state_e;

  // Queue entry: one classified bit period
  typedef struct packed {
    kind_e           kind;
    logic [CH_W-1:0] first_ch;
    logic [CH_W-1:0] last_ch;
    logic            dout;
  } entry_t;

  // One result item
  typedef struct packed {
    logic                 cs_n;
    logic                 din;
    logic                 sclk_pulse;
    logic                 busy_res;
    logic                 sample_valid;
    logic [DATA_BITS-1:0] sample_value;
    logic [CH_W-1:0]      sample_channel;
    logic                 last_of_scan;
    logic                 request_error;
  } res_t;

endpackage

/* rtl/asrs_req_if.sv */
// ---------------------------------------------------------------------------
// asrs_req_if - input channel of the ADC serial read sequencer
// Valid/ready channel carrying one serial bit period per item.
// ---------------------------------------------------------------------------
interface asrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] channel;
  logic [3:0] channel_count;
  logic       dout;

  modport source (output valid, command, channel, channel_count, dout, input ready);
  modport sink   (input valid, command, channel, channel_count, dout, output ready);
endinterface

/* rtl/asrs_res_if.sv */
// ---------------------------------------------------------------------------
// asrs_res_if - result channel of the ADC serial read sequencer
// Valid/ready channel carrying the pin levels and sample of one bit period.
// ---------------------------------------------------------------------------
interface asrs_res_if;
  logic        valid;
  logic        ready;
  logic        cs_n;
  logic        din;
  logic        sclk_pulse;
  logic        busy_res;
  logic        sample_valid;
  logic [11:0] sample_value;
  logic [2:0]  sample_channel;
  logic        last_of_scan;
  logic        request_error;

  modport source (output valid, cs_n, din, sclk_pulse, busy_res, sample_valid,
                  sample_value, sample_channel, last_of_scan, request_error,
                  input ready);
  modport sink   (input valid, cs_n, din, sclk_pulse, busy_res, sample_valid,
                  sample_value, sample_channel, last_of_scan, request_error,
                  output ready);
endinterface

/* rtl/asrs_front.sv */
// ---------------------------------------------------------------------------
// asrs_front - request classifier
// Decodes the command of each item, range-checks channel and count and
// pushes a classified entry into the queue.
// ---------------------------------------------------------------------------
module asrs_front
  import asrs_pkg::*;
(
  asrs_req_if.sink req_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output entry_t   push_entry_o
);

  logic bad_ch;
  logic bad_cnt;

  // Range checks
  assign bad_ch  = (req_i.channel >= 4'(CHANNELS));
  assign bad_cnt = (req_i.channel_count > 4'(CHANNELS));

  // Classify: empty scan and unknown commands act as plain periods
  always_comb begin
    push_entry_o.kind     = K_PLAIN;
    push_entry_o.first_ch = req_i.channel[CH_W-1:0];
    push_entry_o.last_ch  = req_i.channel[CH_W-1:0];
    push_entry_o.dout     = req_i.dout;
    case (req_i.command)
      CMD_READ: begin
        push_entry_o.kind = bad_ch ? K_BAD : K_READ;
      end
      CMD_SCAN: begin
        push_entry_o.first_ch = '0;
        push_entry_o.last_ch  = CH_W'(req_i.channel_count - 4'd1);
        if (bad_cnt) begin
          push_entry_o.kind = K_BAD;
        end else if (req_i.channel_count != 4'd0) begin
          push_entry_o.kind = K_SCAN;
        end
      end
      default: begin
        push_entry_o.kind = K_PLAIN;
      end
    endcase
  end

  // Handshake passes straight to the queue
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

/* rtl/asrs_queue.sv */
// ---------------------------------------------------------------------------
// asrs_queue - short FIFO between classifier and sequencer
// Register-based queue of classified items so either side can stall.
// ---------------------------------------------------------------------------
module asrs_queue
  import asrs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_entry_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_entry_o
);

  entry_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push;
  logic                pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/asrs_back.sv */
// ---------------------------------------------------------------------------
// asrs_back - conversion sequencer
// Steps the command/spare/data/gap frame one bit period per item, shifts in
// the sample and holds the result item in an output register.
// ---------------------------------------------------------------------------
module asrs_back
  import asrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  entry_t      pop_entry_i,
  asrs_res_if.source  res_o
);

  state_e                 state_q, state_d, eff_state;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d, eff_cnt;
  logic [CH_W-1:0]        cur_q, cur_d, eff_cur;
  logic [CH_W-1:0]        last_q, last_d, eff_last;
  logic [DATA_BITS-1:0]   shift_q, shift_d, eff_shift;
  logic [CHANNELS-1:0]    mask_q;
  res_t                   out_q, res;
  logic                   out_valid_q, out_valid_d;
  logic                   load_ok;
  logic                   fire;
  logic                   start;
  logic                   idle;

  assign load_ok     = !out_valid_q || res_o.ready;
  assign pop_ready_o = load_ok;
  assign fire        = pop_valid_i && load_ok;
  assign idle        = (state_q == ST_IDLE);
  assign start       = idle && (pop_entry_i.kind == K_READ || pop_entry_i.kind == K_SCAN);

  // A new request makes this period the first command bit
  assign eff_state = start ? ST_CMD : state_q;
  assign eff_cnt   = start ? '0 : cnt_q;
  assign eff_cur   = start ? pop_entry_i.first_ch : cur_q;
  assign eff_last  = start ? pop_entry_i.last_ch : last_q;
  assign eff_shift = start ? '0 : shift_q;

  // Frame sequencing and pin levels for this period
  always_comb begin
    state_d = eff_state;
    cnt_d   = eff_cnt;
    cur_d   = eff_cur;
    last_d  = eff_last;
    shift_d = eff_shift;
    res     = '0;
    res.cs_n = 1'b1;
    case (eff_state)
      ST_CMD: begin
        res.cs_n       = 1'b0;
        res.sclk_pulse = 1'b1;
        res.busy_res   = 1'b1;
        case (eff_cnt)
          4'd0:    res.din = 1'b1;
          4'd1:    res.din = ~mask_q[eff_cur];
          4'd2:    res.din = eff_cur[2];
          4'd3:    res.din = eff_cur[1];
          default: res.din = eff_cur[0];
        endcase
        if (eff_cnt == BIT_CNT_W'(CMD_BITS - 1)) begin
          state_d = ST_SPARE;
          cnt_d   = '0;
        end else begin
          cnt_d = eff_cnt + 1'b1;
        end
      end
      ST_SPARE: begin
        res.cs_n       = 1'b0;
        res.sclk_pulse = 1'b1;
        res.busy_res   = 1'b1;
        if (eff_cnt == BIT_CNT_W'(SPARE_BITS - 1)) begin
          state_d = ST_DATA;
          cnt_d   = '0;
        end else begin
          cnt_d = eff_cnt + 1'b1;
        end
      end
      ST_DATA: begin
        res.cs_n       = 1'b0;
        res.sclk_pulse = 1'b1;
        res.busy_res   = 1'b1;
        shift_d        = {eff_shift[DATA_BITS-2:0], pop_entry_i.dout};
        if (eff_cnt == BIT_CNT_W'(DATA_BITS - 1)) begin
          res.sample_valid   = 1'b1;
          res.sample_value   = shift_d;
          res.sample_channel = eff_cur;
          res.last_of_scan   = (eff_cur == eff_last);
          state_d            = ST_GAP;
          cnt_d              = '0;
        end else begin
          cnt_d = eff_cnt + 1'b1;
        end
      end
      ST_GAP: begin
        res.busy_res = 1'b1;
        shift_d      = '0;
        cnt_d        = '0;
        if (eff_cur == eff_last) begin
          state_d = ST_IDLE;
        end else begin
          cur_d   = eff_cur + 1'b1;
          state_d = ST_CMD;
        end
      end
      default: begin
        // idle: only a rejected request shows
        res.request_error = (pop_entry_i.kind == K_BAD);
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      last_q      <= '0;
      shift_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i[CHANNELS-1:0];
      end
      if (fire) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        cur_q   <= cur_d;
        last_q  <= last_d;
        shift_q <= shift_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.cs_n           = out_q.cs_n;
  assign res_o.din            = out_q.din;
  assign res_o.sclk_pulse     = out_q.sclk_pulse;
  assign res_o.busy_res       = out_q.busy_res;
  assign res_o.sample_valid   = out_q.sample_valid;
  assign res_o.sample_value   = out_q.sample_value;
  assign res_o.sample_channel = out_q.sample_channel;
  assign res_o.last_of_scan   = out_q.last_of_scan;
  assign res_o.request_error  = out_q.request_error;

`ifndef SYNTHESIS
  // A finished sample always belongs to a busy period
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.sample_valid |-> out_q.busy_res)
    else $error("sample outside a conversion");

  // Rejections only happen while idle
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.request_error |-> !out_q.busy_res && out_q.cs_n)
    else $error("request error during a conversion");

  // The last gap of a request returns to idle
  a_gap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && state_q == ST_GAP && cur_q == last_q |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle");

  // A sample item is produced exactly when the last data bit is stepped
  a_sample_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && state_q == ST_DATA && cnt_q == BIT_CNT_W'(DATA_BITS - 1)
    |=> out_valid_q && out_q.sample_valid && state_q == ST_GAP)
    else $error("missing sample at end of data bits");
`endif

endmodule

/* rtl/adc_serial_read_sequencer.sv */
// ---------------------------------------------------------------------------
// adc_serial_read_sequencer - bit-serial master for an 8-channel 12-bit ADC
// Classifier, two-entry queue and conversion sequencer with output register.
// ---------------------------------------------------------------------------
// Each accepted item is one serial bit period and produces exactly one result
// item with the chip select, data-in and clock-pulse levels for that period.
// The block takes one item per clock when the result side keeps up; an item
// is first stored in the queue, and its result is then registered in the
// output register before it is offered. A conversion spans 20 items: five
// command bits, two spare clocks, twelve data bits sampled MSB first and one
// period with chip select high. A scan runs channels 0..count-1 back to back.
// Commands arriving during a conversion are ignored; an out-of-range channel
// or count raises request_error for that item only. The user must write the
// differential mask through cfg_we_i/cfg_wdata_i only while no conversion is
// in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module adc_serial_read_sequencer
  import asrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  asrs_req_if.sink   req_i,
  asrs_res_if.source res_o
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Front: decode and range-check
  asrs_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Decoupling queue
  asrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Back: frame sequencer
  asrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .res_o       (res_o)
  );

endmodule

/* tb/sv/adc_serial_read_sequencer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_serial_read_sequencer_tb - self-checking bench for the ADC read sequencer
// Feeds serial bit periods through the valid/ready request channel and checks
// every result item, field by field, against a cycle-free sequencer model kept
// in the bench. A short directed table covers the range checks, the empty scan,
// the unknown command and a full-scale conversion. Random phases follow under
// several differential masks, with random idling on both sides.
// ---------------------------------------------------------------------------
module adc_serial_read_sequencer_tb;
  import asrs_pkg::*;

  // Unused command code, behaves as a plain period
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Period numbers within one conversion
  localparam int PH_START_BIT  = 1;
  localparam int PH_MODE_BIT   = 2;
  localparam int PH_CH_MSB     = 3;
  localparam int PH_CH_MID     = 4;
  localparam int PH_LAST_CMD   = CMD_BITS;
  localparam int PH_FIRST_DATA = CMD_BITS + SPARE_BITS + 1;
  localparam int PH_LAST_DATA  = CMD_BITS + SPARE_BITS + DATA_BITS;
  localparam int PH_GAP        = PH_LAST_DATA + 1;

  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 230;

  // Results that can be read off directly
  localparam res_t IDLE_RES  = '{cs_n: 1'b1, default: '0};
  localparam res_t ERR_RES   = '{cs_n: 1'b1, request_error: 1'b1, default: '0};
  localparam res_t START_RES = '{din: 1'b1, sclk_pulse: 1'b1, busy_res: 1'b1,
                                 default: '0};

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] channel;
    logic [3:0] channel_count;
    logic       dout;
  } period_t;

  typedef struct {
    period_t item;
    int      reps;
    bit      typed;
    res_t    want;
  } dir_row_t;

  // Directed table: item, repeat count, typed expectation
  dir_row_t dir_tab [9] = '{
    // all-ones fields on a plain period change nothing
    '{'{CMD_TICK, 4'd15, 4'd15, 1'b1}, 1, 1'b1, IDLE_RES},
    // unknown command code
    '{'{CMD_UNUSED, 4'd0, 4'd0, 1'b0}, 1, 1'b1, IDLE_RES},
    // channel just out of range, then widest channel
    '{'{CMD_READ, 4'd8, 4'd0, 1'b0}, 1, 1'b1, ERR_RES},
    '{'{CMD_READ, 4'd15, 4'd15, 1'b1}, 1, 1'b1, ERR_RES},
    // scan count one past range
    '{'{CMD_SCAN, 4'd0, 4'd9, 1'b0}, 1, 1'b1, ERR_RES},
    // empty scan: accepted, nothing happens, no error
    '{'{CMD_SCAN, 4'd0, 4'd0, 1'b1}, 1, 1'b1, IDLE_RES},
    // top channel, the start period drives the start bit at once
    '{'{CMD_READ, 4'd7, 4'd0, 1'b1}, 1, 1'b1, START_RES},
    // bad scan during a conversion is ignored
    '{'{CMD_SCAN, 4'd15, 4'd15, 1'b1}, 1, 1'b0, '0},
    // rest of the conversion with dout high: full-scale sample
    '{'{CMD_TICK, 4'd0, 4'd0, 1'b1}, 18, 1'b0, '0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  asrs_req_if req_if ();
  asrs_res_if res_if ();

  adc_serial_read_sequencer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // Sequencer model state, at reset values
  logic [7:0]  diff_mask   = '0;
  logic [4:0]  seq_phase   = '0;
  logic [2:0]  conv_ch     = '0;
  logic [2:0]  final_ch    = '0;
  logic [11:0] shift_acc   = '0;
  bit          conv_active = 1'b0;

  res_t pin_levels_q [$];
  int   mismatch_cnt = 0;
  bit   src_no_idle  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One bit period of the sequencer: returns the pin levels and sample
  function automatic res_t advance_sequencer(period_t it);
    res_t       r;
    bit         start;
    logic [2:0] first_ch;
    logic [2:0] stop_ch;
    r = '0;
    r.cs_n = 1'b1;
    start = 1'b0;
    first_ch = '0;
    stop_ch = '0;
    // commands count only while idle
    if (!conv_active) begin
      if (it.command == CMD_READ) begin
        if (it.channel >= CHANNELS) begin
          r.request_error = 1'b1;
        end else begin
          start = 1'b1;
          first_ch = it.channel[2:0];
          stop_ch = it.channel[2:0];
        end
      end else if (it.command == CMD_SCAN) begin
        if (it.channel_count > CHANNELS) begin
          r.request_error = 1'b1;
        end else if (it.channel_count != 0) begin
          start = 1'b1;
          stop_ch = 3'(it.channel_count - 1);
        end
      end
    end
    if (start) begin
      conv_active = 1'b1;
      seq_phase = 5'(PH_START_BIT);
      conv_ch = first_ch;
      final_ch = stop_ch;
      shift_acc = '0;
    end
    // pins for the current period
    if (conv_active) begin
      r.busy_res = 1'b1;
      if (seq_phase != PH_GAP) begin
        r.cs_n = 1'b0;
        r.sclk_pulse = 1'b1;
      end
      if (seq_phase <= PH_LAST_CMD) begin
        case (seq_phase)
          PH_START_BIT: r.din = 1'b1;
          PH_MODE_BIT:  r.din = ~diff_mask[conv_ch];
          PH_CH_MSB:    r.din = conv_ch[2];
          PH_CH_MID:    r.din = conv_ch[1];
          default:      r.din = conv_ch[0];
        endcase
      end else if (seq_phase >= PH_FIRST_DATA && seq_phase <= PH_LAST_DATA) begin
        // data bits arrive MSB first
        shift_acc[PH_LAST_DATA - seq_phase] = it.dout;
        if (seq_phase == PH_LAST_DATA) begin
          r.sample_valid = 1'b1;
          r.sample_value = shift_acc;
          r.sample_channel = conv_ch;
          r.last_of_scan = (conv_ch == final_ch);
        end
      end
      // next period, next channel after the gap
      if (seq_phase == PH_GAP) begin
        shift_acc = '0;
        if (conv_ch == final_ch) begin
          conv_active = 1'b0;
          seq_phase = '0;
        end else begin
          conv_ch = conv_ch + 3'd1;
          seq_phase = 5'(PH_START_BIT);
        end
      end else begin
        seq_phase = seq_phase + 5'd1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  // Offer one item, wait for it to be taken, then queue its expected result
  task automatic send_period(input period_t it, input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t        r;
    if ($urandom_range(0, 39) == 0) src_no_idle = !src_no_idle;
    gap = src_no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= it.command;
    req_if.channel       <= it.channel;
    req_if.channel_count <= it.channel_count;
    req_if.dout          <= it.dout;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    r = advance_sequencer(it);
    pin_levels_q.push_back(typed ? typed_res : r);
  endtask

  // Stimulus: directed table, then random phases under different masks
  initial begin : stimulus
    period_t     it;
    int unsigned sel;
    logic [7:0]  mask_val;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    req_if.valid         <= 1'b0;
    req_if.command       <= CMD_TICK;
    req_if.channel       <= '0;
    req_if.channel_count <= '0;
    req_if.dout          <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[row])
      repeat (dir_tab[row].reps)
        send_period(dir_tab[row].item, dir_tab[row].typed, dir_tab[row].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // finish the conversion in flight, let the pipeline empty, then write
      while (conv_active) begin
        it = '{CMD_TICK, 4'($urandom), 4'($urandom), 1'($urandom)};
        send_period(it, 1'b0, '0);
      end
      req_if.valid <= 1'b0;
      while (pin_levels_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      case (ph)
        0:       mask_val = 8'hFF;
        1:       mask_val = 8'h00;
        2:       mask_val = 8'h5A;
        default: mask_val = 8'($urandom);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= mask_val;
      @(posedge clk_i);
      cfg_we_i  <= 1'b0;
      diff_mask = mask_val;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it = '{CMD_TICK, 4'($urandom), 4'($urandom), 1'($urandom)};
        if (!conv_active) begin
          // mostly well-formed requests, some bad ones and noise
          sel = $urandom_range(0, 99);
          if (sel < 40) begin
            it.command = CMD_READ;
            it.channel = 4'($urandom_range(0, CHANNELS - 1));
          end else if (sel < 66) begin
            it.command = CMD_SCAN;
            it.channel_count = 4'($urandom_range(1, 3));
          end else if (sel < 74) begin
            it.command = CMD_SCAN;
            it.channel_count = 4'($urandom_range(4, CHANNELS));
          end else if (sel < 78) begin
            it.command = CMD_SCAN;
            it.channel_count = 4'(CHANNELS);
          end else if (sel < 84) begin
            it.command = CMD_READ;
            it.channel = 4'($urandom_range(CHANNELS, 15));
          end else if (sel < 89) begin
            it.command = CMD_SCAN;
            it.channel_count = 4'($urandom_range(CHANNELS + 1, 15));
          end else if (sel < 92) begin
            it.command = CMD_SCAN;
            it.channel_count = '0;
          end else if (sel < 96) begin
            it.command = CMD_UNUSED;
          end
        end else if ($urandom_range(0, 11) == 0) begin
          // stray command mid-conversion
          it.command = 2'($urandom);
        end
        send_period(it, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("[adc_serial_read_sequencer] OK");
    else
      $display("[adc_serial_read_sequencer] ERROR");
    $finish;
  end

  // Result side: random stalls, two long hold-offs, field-by-field compare
  initial begin : result_sink
    res_t        got;
    res_t        want;
    int unsigned stall;
    int unsigned taken;
    bit          no_idle;
    taken = 0;
    no_idle = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      stall = no_idle ? 0 : $urandom_range(0, 14);
      // long hold so the queue fills and the request side backs up
      if (taken == 250 || taken == 800) stall = 150;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      got = {res_if.cs_n, res_if.din, res_if.sclk_pulse, res_if.busy_res,
             res_if.sample_valid, res_if.sample_value, res_if.sample_channel,
             res_if.last_of_scan, res_if.request_error};
      taken++;
      if (pin_levels_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result item with none expected, expected none, actual %h",
                 $time, got);
      end else begin
        want = pin_levels_q.pop_front();
        check_field("cs_n", want.cs_n, got.cs_n);
        check_field("din", want.din, got.din);
        check_field("sclk_pulse", want.sclk_pulse, got.sclk_pulse);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("sample_valid", want.sample_valid, got.sample_valid);
        check_field("sample_value", want.sample_value, got.sample_value);
        check_field("sample_channel", want.sample_channel, got.sample_channel);
        check_field("last_of_scan", want.last_of_scan, got.last_of_scan);
        check_field("request_error", want.request_error, got.request_error);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #8_000_000;
    $display("[adc_serial_read_sequencer] ERROR");
    $finish;
  end

endmodule

/* adc_serial_read_sequencer.f */
rtl/asrs_pkg.sv
rtl/asrs_req_if.sv
rtl/asrs_res_if.sv
rtl/asrs_front.sv
rtl/asrs_queue.sv
rtl/asrs_back.sv
rtl/adc_serial_read_sequencer.sv
tb/sv/adc_serial_read_sequencer_tb.sv
